/* src/lr_pkg.sv */
// Shared control and status types for the line rasterizer.
`timescale 1ns / 1ps

package lr_pkg;

    typedef struct packed {
        logic load;
        logic advance;
    } lr_ctrl_t;

    typedef struct packed {
        logic load_empty;
        logic empty;
        logic last;
    } lr_status_t;

endpackage

/* src/lr_bres_core.sv */
// Bresenham stepping core: endpoint ordering and one shared error adder.
`timescale 1ns / 1ps

module lr_bres_core #(
    parameter int COORD_BITS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lr_pkg::lr_ctrl_t      ctrl,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output lr_pkg::lr_status_t    status
);

    localparam int DW = COORD_BITS + 3;

    logic                  x_swap;
    logic                  y_swap;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  col_major;
    logic                  ord_swap;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic [COORD_BITS-1:0] maj_init;
    logic [COORD_BITS-1:0] min_init;
    logic [COORD_BITS-1:0] min_end;
    logic [COORD_BITS-1:0] dmaj;
    logic [COORD_BITS-1:0] dmin;
    logic signed [DW-1:0]  dmaj_ext;
    logic signed [DW-1:0]  dmin_ext;
    logic signed [DW-1:0]  d_init;
    logic signed [DW-1:0]  hi_init;
    logic signed [DW-1:0]  lo_init;

    logic                  col_major_reg;
    logic                  dir_reg;
    logic [COORD_BITS-1:0] maj_reg;
    logic [COORD_BITS-1:0] min_reg;
    logic [COORD_BITS-1:0] cnt_reg;
    logic signed [DW-1:0]  d_reg;
    logic signed [DW-1:0]  d_hi_reg;
    logic signed [DW-1:0]  d_lo_reg;

    logic                  d_pos;
    logic signed [DW-1:0]  d_next;
    logic [COORD_BITS-1:0] min_step;
    logic [COORD_BITS-1:0] min_next;

    always_comb begin
        x_swap    = start_x > end_x;
        y_swap    = start_y > end_y;
        adx       = x_swap ? start_x - end_x : end_x - start_x;
        ady       = y_swap ? start_y - end_y : end_y - start_y;
        col_major = ady < adx;
        ord_swap  = col_major ? x_swap : y_swap;
        ax        = ord_swap ? end_x : start_x;
        ay        = ord_swap ? end_y : start_y;
        bx        = ord_swap ? start_x : end_x;
        by        = ord_swap ? start_y : end_y;
        maj_init  = col_major ? ax : ay;
        min_init  = col_major ? ay : ax;
        min_end   = col_major ? by : bx;
        dmaj      = col_major ? adx : ady;
        dmin      = col_major ? ady : adx;
        dmaj_ext  = $signed({3'b000, dmaj});
        dmin_ext  = $signed({3'b000, dmin});
        d_init    = (dmin_ext <<< 1) - dmaj_ext;
        hi_init   = (dmin_ext - dmaj_ext) <<< 1;
        lo_init   = dmin_ext <<< 1;
    end

    always_comb begin
        d_pos    = d_reg > $signed({DW{1'b0}});
        d_next   = d_reg + (d_pos ? d_hi_reg : d_lo_reg);
        min_step = dir_reg ? min_reg - COORD_BITS'(1) : min_reg + COORD_BITS'(1);
        min_next = d_pos ? min_step : min_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctrl.load) begin
            col_major_reg <= col_major;
            dir_reg       <= min_end < min_init;
            maj_reg       <= maj_init;
            min_reg       <= min_init;
            cnt_reg       <= dmaj;
            d_reg         <= d_init;
            d_hi_reg      <= hi_init;
            d_lo_reg      <= lo_init;
        end else if (ctrl.advance) begin
            maj_reg <= maj_reg + COORD_BITS'(1);
            min_reg <= min_next;
            cnt_reg <= cnt_reg - COORD_BITS'(1);
            d_reg   <= d_next;
        end
    end

    assign pixel_x           = col_major_reg ? maj_reg : min_reg;
    assign pixel_y           = col_major_reg ? min_reg : maj_reg;
    assign status.load_empty = dmaj == '0;
    assign status.empty      = cnt_reg == '0;
    assign status.last       = cnt_reg == COORD_BITS'(1);

endmodule

/* src/line_rasterizer_top.sv */
// Line rasterizer top level: input capture, sequencer and pixel output register.
// The first pixel is registered in the run state, after setup loads the core.
// Throughput: one pixel per cycle from the shared error adder unless the output
// stalls on m_ready; ready is low while a line runs.
// Reset: synchronous active-low aresetn clears the sequencer, the pixel count and
// the output valid; no memory, no clearing pass.
`timescale 1ns / 1ps

module line_rasterizer_top #(
    parameter int COORD_BITS = 6,
    parameter int COLOR_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic [COLOR_BITS-1:0] s_line_color,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_pixel_color,
    output logic                  m_last_pixel
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t                state_reg;
    logic [COORD_BITS-1:0] x0_reg;
    logic [COORD_BITS-1:0] y0_reg;
    logic [COORD_BITS-1:0] x1_reg;
    logic [COORD_BITS-1:0] y1_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  m_valid_reg;
    logic [COORD_BITS-1:0] m_x_reg;
    logic [COORD_BITS-1:0] m_y_reg;
    logic [COLOR_BITS-1:0] m_color_reg;
    logic                  m_last_reg;

    logic                  out_free;
    lr_pkg::lr_ctrl_t      ctrl;
    lr_pkg::lr_status_t    status;
    logic [COORD_BITS-1:0] core_x;
    logic [COORD_BITS-1:0] core_y;

    assign s_ready      = state_reg == ST_IDLE;
    assign out_free     = !m_valid_reg || m_ready;
    assign ctrl.load    = state_reg == ST_SETUP;
    assign ctrl.advance = (state_reg == ST_RUN) && out_free;

    lr_bres_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .start_x(x0_reg),
        .start_y(y0_reg),
        .end_x  (x1_reg),
        .end_y  (y1_reg),
        .pixel_x(core_x),
        .pixel_y(core_y),
        .status (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !ctrl.advance) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x0_reg    <= s_start_x;
                        y0_reg    <= s_start_y;
                        x1_reg    <= s_end_x;
                        y1_reg    <= s_end_y;
                        color_reg <= s_line_color;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    state_reg <= status.load_empty ? ST_IDLE : ST_RUN;
                end
                ST_RUN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_x_reg     <= core_x;
                        m_y_reg     <= core_y;
                        m_color_reg <= color_reg;
                        m_last_reg  <= status.last;
                        if (status.last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_color = m_color_reg;
    assign m_last_pixel  = m_last_reg;

    a_accept_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SETUP))
        else $error("accepted line did not enter setup");

    a_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> !status.empty)
        else $error("running with no pixels left");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.advance && status.last) |=> (state_reg == ST_IDLE) && m_valid_reg && m_last_reg)
        else $error("final pixel did not end the line");

    a_setup_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.load && status.load_empty) |=> (state_reg == ST_IDLE) && status.empty)
        else $error("empty line did not return to idle");

endmodule
